>>> rtl/r16_pkg.sv
package r16_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned XLEN          = 16;
  localparam logic [16:0] PROG_END_RST  = 17'h10000;

  typedef enum logic [2:0] {
    CLS_R   = 3'd0,
    CLS_I   = 3'd1,
    CLS_S   = 3'd2,
    CLS_B   = 3'd3,
    CLS_L   = 3'd4,
    CLS_J   = 3'd5,
    CLS_U   = 3'd6,
    CLS_NOP = 3'd7
  } cls_e;

  // r-type keys {func4, func3}
  localparam logic [6:0] R_ADD  = 7'h00;
  localparam logic [6:0] R_SUB  = 7'h08;
  localparam logic [6:0] R_SLT  = 7'h11;
  localparam logic [6:0] R_SLTU = 7'h1A;
  localparam logic [6:0] R_SLL  = 7'h23;
  localparam logic [6:0] R_SRL  = 7'h2B;
  localparam logic [6:0] R_SRA  = 7'h33;
  localparam logic [6:0] R_OR   = 7'h3C;
  localparam logic [6:0] R_AND  = 7'h45;
  localparam logic [6:0] R_XOR  = 7'h4E;
  localparam logic [6:0] R_MV   = 7'h57;
  localparam logic [6:0] R_JR   = 7'h58;
  localparam logic [6:0] R_JALR = 7'h60;

  localparam logic [2:0] I_ADDI  = 3'd0;
  localparam logic [2:0] I_SLTI  = 3'd1;
  localparam logic [2:0] I_SLTUI = 3'd2;
  localparam logic [2:0] I_SHIFT = 3'd3;
  localparam logic [2:0] I_ORI   = 3'd4;
  localparam logic [2:0] I_ANDI  = 3'd5;
  localparam logic [2:0] I_XORI  = 3'd6;
  localparam logic [2:0] I_LI    = 3'd7;

  localparam logic [3:0] SH_SLL = 4'd1;
  localparam logic [3:0] SH_SRL = 4'd2;
  localparam logic [3:0] SH_SRA = 4'd4;

  localparam logic [2:0] MEM_B  = 3'b000;
  localparam logic [2:0] MEM_W  = 3'b001;
  localparam logic [2:0] MEM_BU = 3'b100;

  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_EZ  = 3'd2;
  localparam logic [2:0] BR_NZ  = 3'd3;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  typedef struct packed {
    logic              operation;
    logic [2:0]        instr_class;
    logic [3:0]        func4;
    logic [2:0]        func3;
    logic [2:0]        rd_index;
    logic [2:0]        rs1_index;
    logic [2:0]        rs2_index;
    logic signed [8:0] immediate;
    logic              link_flag;
    logic [15:0]       preload_address;
    logic [7:0]        preload_byte;
  } item_t;

  typedef struct packed {
    logic        st_en;
    logic        is_load;
    logic        word;
    logic        sext;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        jumped;
    logic        wr;
    logic [15:0] wval;
    logic        unk;
    logic        fault;
    logic        halted;
    mem_req_t    mem;
  } exec_res_t;

endpackage

>>> rtl/r16_intf.sv
interface r16_req_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [2:0]        instr_class;
  logic [3:0]        func4;
  logic [2:0]        func3;
  logic [2:0]        rd_index;
  logic [2:0]        rs1_index;
  logic [2:0]        rs2_index;
  logic signed [8:0] immediate;
  logic              link_flag;
  logic [15:0]       preload_address;
  logic [7:0]        preload_byte;

  modport source (
    output valid, operation, instr_class, func4, func3, rd_index, rs1_index, rs2_index,
    output immediate, link_flag, preload_address, preload_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, instr_class, func4, func3, rd_index, rs1_index, rs2_index,
    input  immediate, link_flag, preload_address, preload_byte,
    output ready
  );
endinterface

interface r16_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        took_jump;
  logic        reg_written;
  logic [2:0]  dest_index;
  logic [15:0] dest_value;
  logic        unknown_op;
  logic        memory_fault;
  logic        halted_now;

  modport source (
    output valid, next_pc, took_jump, reg_written, dest_index, dest_value,
    output unknown_op, memory_fault, halted_now,
    input  ready
  );
  modport sink (
    input  valid, next_pc, took_jump, reg_written, dest_index, dest_value,
    input  unknown_op, memory_fault, halted_now,
    output ready
  );
endinterface

interface r16_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] program_end;

  modport source (output valid, program_end, input ready);
  modport sink (input valid, program_end, output ready);
endinterface

>>> rtl/r16_ram.sv
module r16_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 256
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b_i,
  output logic [DATA_W-1:0]          rdata_a_o,
  output logic [DATA_W-1:0]          rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> rtl/r16_alu.sv
module r16_alu #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  r16_pkg::item_t    item_i,
  input  logic [15:0]       pc_i,
  input  logic              halt_i,
  input  logic [16:0]       prog_end_i,
  input  logic [15:0]       opa_i,
  input  logic [15:0]       opb_i,
  output r16_pkg::exec_res_t res_o
);
  import r16_pkg::*;

  localparam logic [16:0] MemLimit = 17'(MEM_BYTES);

  always_comb begin
    logic [15:0] imm;
    logic [15:0] npc;
    logic [15:0] tgt;
    logic [15:0] addr;
    logic [6:0]  key;
    logic        cond;
    logic        wr;
    logic        jmp;
    logic [15:0] wval;
    logic        unk;
    logic        fault;
    mem_req_t    mem;

    imm   = {{7{item_i.immediate[8]}}, item_i.immediate};
    npc   = pc_i + 16'd2;
    tgt   = pc_i + imm + 16'd2;
    key   = {item_i.func4, item_i.func3};
    cond  = 1'b0;
    wr    = 1'b0;
    jmp   = 1'b0;
    wval  = '0;
    unk   = 1'b0;
    fault = 1'b0;
    mem   = '0;
    addr  = '0;

    res_o         = '0;
    res_o.next_pc = pc_i;
    res_o.halted  = halt_i;

    if (item_i.operation) begin
      // preload
      if ({1'b0, item_i.preload_address} < MemLimit) begin
        mem.st_en = 1'b1;
        mem.addr  = item_i.preload_address;
        mem.wdata = {8'h00, item_i.preload_byte};
      end else begin
        fault = 1'b1;
      end
      res_o.fault = fault;
      res_o.mem   = mem;
    end else if (!halt_i) begin
      if ({1'b0, pc_i} >= prog_end_i) begin
        res_o.halted = 1'b1;
      end else begin
        unique case (cls_e'(item_i.instr_class))
          CLS_R: begin
            wr = 1'b1;
            unique case (key)
              R_ADD:  wval = opa_i + opb_i;
              R_SUB:  wval = opa_i - opb_i;
              R_SLT:  wval = {15'd0, $signed(opa_i) < $signed(opb_i)};
              R_SLTU: wval = {15'd0, opa_i < opb_i};
              R_SLL:  wval = opa_i << opb_i[3:0];
              R_SRL:  wval = opa_i >> opb_i[3:0];
              R_SRA:  wval = 16'($signed(opa_i) >>> opb_i[3:0]);
              R_OR:   wval = opa_i | opb_i;
              R_AND:  wval = opa_i & opb_i;
              R_XOR:  wval = opa_i ^ opb_i;
              R_MV:   wval = opb_i;
              R_JR: begin
                wr  = 1'b0;
                jmp = 1'b1;
                npc = opa_i;
              end
              R_JALR: begin
                wval = pc_i + 16'd2;
                jmp  = 1'b1;
                npc  = opb_i;
              end
              default: begin
                wr  = 1'b0;
                unk = 1'b1;
              end
            endcase
          end
          CLS_I: begin
            wr = 1'b1;
            unique case (item_i.func3)
              I_ADDI:  wval = opa_i + imm;
              I_SLTI:  wval = {15'd0, $signed(opa_i) < $signed(imm)};
              I_SLTUI: wval = {15'd0, opa_i < imm};
              I_SHIFT: begin
                unique case (item_i.func4)
                  SH_SLL:  wval = opa_i << imm[3:0];
                  SH_SRL:  wval = opa_i >> imm[3:0];
                  SH_SRA:  wval = 16'($signed(opa_i) >>> imm[3:0]);
                  default: begin
                    wr  = 1'b0;
                    unk = 1'b1;
                  end
                endcase
              end
              I_ORI:   wval = opa_i | imm;
              I_ANDI:  wval = opa_i & imm;
              I_XORI:  wval = opa_i ^ imm;
              I_LI:    wval = imm;
              default: wval = imm;
            endcase
          end
          CLS_S: begin
            addr = opa_i + imm;
            if (item_i.func3 == MEM_B) begin
              if ({1'b0, addr} < MemLimit) begin
                mem.st_en = 1'b1;
              end else begin
                fault = 1'b1;
              end
            end else if (item_i.func3 == MEM_W) begin
              if ({1'b0, addr} + 17'd1 < MemLimit) begin
                mem.st_en = 1'b1;
                mem.word  = 1'b1;
              end else begin
                fault = 1'b1;
              end
            end else begin
              unk = 1'b1;
            end
            mem.addr  = addr;
            mem.wdata = opb_i;
          end
          CLS_B: begin
            unique case (item_i.func3)
              BR_EQ:   cond = opa_i == opb_i;
              BR_NE:   cond = opa_i != opb_i;
              BR_EZ:   cond = opa_i == 16'd0;
              BR_NZ:   cond = opa_i != 16'd0;
              BR_LT:   cond = $signed(opa_i) < $signed(opb_i);
              BR_GE:   cond = !($signed(opa_i) < $signed(opb_i));
              BR_LTU:  cond = opa_i < opb_i;
              BR_GEU:  cond = opa_i >= opb_i;
              default: cond = 1'b0;
            endcase
            if (cond) begin
              jmp = 1'b1;
              npc = tgt;
            end
          end
          CLS_L: begin
            addr     = opb_i + imm;
            mem.addr = addr;
            if (item_i.func3 == MEM_B || item_i.func3 == MEM_BU) begin
              if ({1'b0, addr} < MemLimit) begin
                wr          = 1'b1;
                mem.is_load = 1'b1;
                mem.sext    = item_i.func3 == MEM_B;
              end else begin
                fault = 1'b1;
              end
            end else if (item_i.func3 == MEM_W) begin
              if ({1'b0, addr} + 17'd1 < MemLimit) begin
                wr          = 1'b1;
                mem.is_load = 1'b1;
                mem.word    = 1'b1;
              end else begin
                fault = 1'b1;
              end
            end else begin
              unk = 1'b1;
            end
          end
          CLS_J: begin
            if (item_i.link_flag) begin
              wr   = 1'b1;
              wval = pc_i + 16'd2;
            end
            jmp = 1'b1;
            npc = tgt;
          end
          CLS_U: begin
            wr   = 1'b1;
            wval = imm << 7;
            if (item_i.link_flag) begin
              wval = wval + pc_i;
            end
          end
          CLS_NOP: begin
            wr = 1'b0;
          end
          default: begin
            wr = 1'b0;
          end
        endcase
        res_o.next_pc = npc;
        res_o.jumped  = jmp;
        res_o.wr      = wr;
        res_o.wval    = wval;
        res_o.unk     = unk;
        res_o.fault   = fault;
        res_o.mem     = mem;
        res_o.halted  = {1'b0, npc} >= prog_end_i;
      end
    end
  end

endmodule

>>> rtl/risc16_execute_unit.sv
// Execute unit for a small 16-bit RISC machine: takes one decoded instruction or one
// memory preload byte per request and returns one response per request, in order. A new
// request is taken every cycle unless the response register is held by a stalled
// consumer; each request first passes through execute, where the
// register file read issued at acceptance is completed with bypass from the two most
// recent writes, and then sits in the response register, where a load picks up the byte
// banks' registered read data. Data memory is two byte-wide banks (even and odd
// addresses) so a word access of either alignment uses both banks in one access; it
// needs no clearing after reset. The user must write program_end only while the unit
// is idle; the unit itself does not enforce this.
module risc16_execute_unit #(
  parameter int unsigned MEM_BYTES = r16_pkg::MEM_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  r16_req_if.sink   req_i,
  r16_rsp_if.source rsp_o,
  r16_cfg_if.sink   cfg_i
);
  import r16_pkg::*;

  localparam int unsigned AddrW = $clog2(MEM_BYTES);
  localparam int unsigned RowW  = AddrW - 1;
  localparam int unsigned Rows  = MEM_BYTES / 2;
  localparam int unsigned RegW  = $clog2(NUM_REGS);

  logic adv;
  logic acc;

  logic [16:0] prog_end_q;
  logic [15:0] pc_q;
  logic        halt_q;

  // execute stage
  logic        e_valid_q;
  item_t       e_item_q;
  logic [2:0]  e_pa_idx_q;
  logic        e_pa_vld_q;
  logic        e_pb_vld_q;

  // response stage
  logic        w_valid_q;
  logic [15:0] w_next_pc_q;
  logic        w_jumped_q;
  logic        w_wr_q;
  logic [2:0]  w_rd_q;
  logic [15:0] w_wval_q;
  logic        w_unk_q;
  logic        w_fault_q;
  logic        w_halted_q;
  logic        w_load_q;
  logic        w_word_q;
  logic        w_sext_q;
  logic        w_a0_q;

  // last register write
  logic        lw_valid_q;
  logic [2:0]  lw_idx_q;
  logic [15:0] lw_val_q;

  logic [NUM_REGS-1:0] rf_valid_q;

  item_t       in_item;
  logic [2:0]  pa_sel;
  logic [15:0] rf_a;
  logic [15:0] rf_b;
  logic        rf_we;
  logic [15:0] opa;
  logic [15:0] opb;
  exec_res_t   res;

  logic [7:0]  even_q;
  logic [7:0]  odd_q;
  logic [RowW-1:0] even_row;
  logic [RowW-1:0] odd_row;
  logic        we_even;
  logic        we_odd;
  logic [7:0]  wd_even;
  logic [7:0]  wd_odd;
  logic [7:0]  ld_lo;
  logic [7:0]  ld_hi;
  logic [15:0] w_value;

  assign adv         = !w_valid_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign acc         = req_i.valid && adv;
  assign cfg_i.ready = 1'b1;

  assign in_item = '{
    operation:       req_i.operation,
    instr_class:     req_i.instr_class,
    func4:           req_i.func4,
    func3:           req_i.func3,
    rd_index:        req_i.rd_index,
    rs1_index:       req_i.rs1_index,
    rs2_index:       req_i.rs2_index,
    immediate:       req_i.immediate,
    link_flag:       req_i.link_flag,
    preload_address: req_i.preload_address,
    preload_byte:    req_i.preload_byte
  };

  // stores and branches use rs1 where the others use rd
  assign pa_sel = (req_i.instr_class == CLS_S || req_i.instr_class == CLS_B) ?
                  req_i.rs1_index : req_i.rd_index;

  assign rf_we = adv && w_valid_q && w_wr_q;

  r16_ram #(
    .DATA_W (XLEN),
    .DEPTH  (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (w_rd_q),
    .wdata_i   (w_value),
    .re_i      (acc),
    .raddr_a_i (pa_sel),
    .raddr_b_i (req_i.rs2_index),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  // load data of the response stage
  assign ld_lo   = w_a0_q ? odd_q : even_q;
  assign ld_hi   = w_a0_q ? even_q : odd_q;
  assign w_value = !w_load_q ? w_wval_q :
                   w_word_q  ? {ld_hi, ld_lo} :
                   w_sext_q  ? {{8{ld_lo[7]}}, ld_lo} : {8'h00, ld_lo};

  // operand bypass
  always_comb begin
    if (w_valid_q && w_wr_q && w_rd_q == e_pa_idx_q) begin
      opa = w_value;
    end else if (lw_valid_q && lw_idx_q == e_pa_idx_q) begin
      opa = lw_val_q;
    end else if (e_pa_vld_q) begin
      opa = rf_a;
    end else begin
      opa = '0;
    end
    if (w_valid_q && w_wr_q && w_rd_q == e_item_q.rs2_index) begin
      opb = w_value;
    end else if (lw_valid_q && lw_idx_q == e_item_q.rs2_index) begin
      opb = lw_val_q;
    end else if (e_pb_vld_q) begin
      opb = rf_b;
    end else begin
      opb = '0;
    end
  end

  r16_alu #(
    .MEM_BYTES (MEM_BYTES)
  ) u_alu (
    .item_i     (e_item_q),
    .pc_i       (pc_q),
    .halt_i     (halt_q),
    .prog_end_i (prog_end_q),
    .opa_i      (opa),
    .opb_i      (opb),
    .res_o      (res)
  );

  // byte banks
  assign odd_row  = res.mem.addr[AddrW-1:1];
  assign even_row = res.mem.addr[AddrW-1:1] + RowW'(res.mem.addr[0]);
  assign we_even  = adv && e_valid_q && res.mem.st_en && (res.mem.word || !res.mem.addr[0]);
  assign we_odd   = adv && e_valid_q && res.mem.st_en && (res.mem.word || res.mem.addr[0]);
  assign wd_even  = (res.mem.word && res.mem.addr[0]) ? res.mem.wdata[15:8] :
                    res.mem.wdata[7:0];
  assign wd_odd   = (res.mem.word && !res.mem.addr[0]) ? res.mem.wdata[15:8] :
                    res.mem.wdata[7:0];

  r16_ram #(
    .DATA_W (8),
    .DEPTH  (Rows)
  ) u_bank_even (
    .clk_i     (clk_i),
    .we_i      (we_even),
    .waddr_i   (even_row),
    .wdata_i   (wd_even),
    .re_i      (adv),
    .raddr_a_i (even_row),
    .raddr_b_i (even_row),
    .rdata_a_o (even_q),
    .rdata_b_o ()
  );

  r16_ram #(
    .DATA_W (8),
    .DEPTH  (Rows)
  ) u_bank_odd (
    .clk_i     (clk_i),
    .we_i      (we_odd),
    .waddr_i   (odd_row),
    .wdata_i   (wd_odd),
    .re_i      (adv),
    .raddr_a_i (odd_row),
    .raddr_b_i (odd_row),
    .rdata_a_o (odd_q),
    .rdata_b_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_end_q <= PROG_END_RST;
      pc_q       <= '0;
      halt_q     <= 1'b0;
      e_valid_q  <= 1'b0;
      w_valid_q  <= 1'b0;
      lw_valid_q <= 1'b0;
      rf_valid_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        prog_end_q <= cfg_i.program_end;
      end
      if (adv) begin
        e_valid_q  <= acc;
        w_valid_q  <= e_valid_q;
        lw_valid_q <= w_valid_q && w_wr_q;
        if (e_valid_q) begin
          pc_q   <= res.next_pc;
          halt_q <= res.halted;
        end
      end
      if (rf_we) begin
        rf_valid_q[w_rd_q[RegW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      e_item_q   <= in_item;
      e_pa_idx_q <= pa_sel;
      e_pa_vld_q <= rf_valid_q[pa_sel[RegW-1:0]];
      e_pb_vld_q <= rf_valid_q[req_i.rs2_index[RegW-1:0]];
    end
    if (adv) begin
      lw_idx_q    <= w_rd_q;
      lw_val_q    <= w_value;
      w_next_pc_q <= res.next_pc;
      w_jumped_q  <= res.jumped;
      w_wr_q      <= res.wr;
      w_rd_q      <= e_item_q.rd_index;
      w_wval_q    <= res.wval;
      w_unk_q     <= res.unk;
      w_fault_q   <= res.fault;
      w_halted_q  <= res.halted;
      w_load_q    <= res.mem.is_load;
      w_word_q    <= res.mem.word;
      w_sext_q    <= res.mem.sext;
      w_a0_q      <= res.mem.addr[0];
    end
  end

  assign rsp_o.valid        = w_valid_q;
  assign rsp_o.next_pc      = w_next_pc_q;
  assign rsp_o.took_jump    = w_jumped_q;
  assign rsp_o.reg_written  = w_wr_q;
  assign rsp_o.dest_index   = w_wr_q ? w_rd_q : 3'd0;
  assign rsp_o.dest_value   = w_wr_q ? w_value : 16'd0;
  assign rsp_o.unknown_op   = w_unk_q;
  assign rsp_o.memory_fault = w_fault_q;
  assign rsp_o.halted_now   = w_halted_q;

  // a held load response keeps its bank data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q && !rsp_o.ready && w_load_q |=> $stable(even_q) && $stable(odd_q))
    else $error("load data changed while response stalled");

  // no memory write while the pipeline is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> !we_even && !we_odd)
    else $error("memory write during stall");

  // once halted the pc stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q && $stable(pc_q))
    else $error("pc moved after halt");

  // a faulting access never writes a register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q && w_fault_q |-> !w_wr_q)
    else $error("register write on memory fault");

endmodule

>>> bench/risc16_execute_unit_test.sv
`timescale 1ns / 100ps

module risc16_execute_unit_test;
  import r16_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        took_jump;
    logic        reg_written;
    logic [2:0]  dest_index;
    logic [15:0] dest_value;
    logic        unknown_op;
    logic        memory_fault;
    logic        halted_now;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  r16_req_if req ();
  r16_rsp_if rsp ();
  r16_cfg_if cfg ();

  risc16_execute_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  // architectural state as the unit should hold it
  logic [15:0] gpr_model [NUM_REGS];
  logic [15:0] pc_model;
  logic        halt_model;
  logic [16:0] prog_end_model;
  logic [7:0]  mem_data [MEM_BYTES_DEF];
  bit          mem_written [MEM_BYTES_DEF];

  outcome_t outcome_q [$];
  int unsigned errors;
  int unsigned cycles;
  bit          no_idle;
  outcome_t    got_rsp;
  outcome_t    want_rsp;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** risc16_execute_unit: FAILED **");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 37);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp.ready <= !idle_now();
    end
  end

  function automatic logic [15:0] sext_imm(logic signed [8:0] imm);
    return {{7{imm[8]}}, imm};
  endfunction

  function automatic outcome_t execute_item(item_t it);
    outcome_t    o;
    logic [15:0] a, b, c, imm, npc, wval, addr;
    logic        wr, jmp, unk, fault, cond;
    o = '0;
    wr = 1'b0;
    jmp = 1'b0;
    unk = 1'b0;
    fault = 1'b0;
    cond = 1'b0;
    wval = '0;
    imm = sext_imm(it.immediate);
    if (it.operation) begin
      mem_data[it.preload_address] = it.preload_byte;
      mem_written[it.preload_address] = 1'b1;
    end else if (!halt_model) begin
      if ({1'b0, pc_model} >= prog_end_model) begin
        halt_model = 1'b1;
      end else begin
        a = gpr_model[it.rd_index];
        b = gpr_model[it.rs2_index];
        c = gpr_model[it.rs1_index];
        npc = pc_model + 16'd2;
        case (it.instr_class)
          CLS_R: begin
            wr = 1'b1;
            case ({it.func4, it.func3})
              R_ADD:  wval = a + b;
              R_SUB:  wval = a - b;
              R_SLT:  wval = 16'($signed(a) < $signed(b));
              R_SLTU: wval = 16'(a < b);
              R_SLL:  wval = a << b[3:0];
              R_SRL:  wval = a >> b[3:0];
              R_SRA:  wval = $signed(a) >>> b[3:0];
              R_OR:   wval = a | b;
              R_AND:  wval = a & b;
              R_XOR:  wval = a ^ b;
              R_MV:   wval = b;
              R_JR: begin
                wr = 1'b0;
                jmp = 1'b1;
                npc = a;
              end
              R_JALR: begin
                wval = pc_model + 16'd2;
                jmp = 1'b1;
                npc = b;
              end
              default: begin
                wr = 1'b0;
                unk = 1'b1;
              end
            endcase
          end
          CLS_I: begin
            wr = 1'b1;
            case (it.func3)
              I_ADDI:  wval = a + imm;
              I_SLTI:  wval = 16'($signed(a) < $signed(imm));
              I_SLTUI: wval = 16'(a < imm);
              I_SHIFT: begin
                case (it.func4)
                  SH_SLL: wval = a << imm[3:0];
                  SH_SRL: wval = a >> imm[3:0];
                  SH_SRA: wval = $signed(a) >>> imm[3:0];
                  default: begin
                    wr = 1'b0;
                    unk = 1'b1;
                  end
                endcase
              end
              I_ORI:   wval = a | imm;
              I_ANDI:  wval = a & imm;
              I_XORI:  wval = a ^ imm;
              default: wval = imm;
            endcase
          end
          CLS_S: begin
            addr = c + imm;
            if (it.func3 == MEM_B) begin
              mem_data[addr] = b[7:0];
              mem_written[addr] = 1'b1;
            end else if (it.func3 == MEM_W) begin
              if (addr == 16'hFFFF) begin
                fault = 1'b1;
              end else begin
                mem_data[addr] = b[7:0];
                mem_data[addr + 16'd1] = b[15:8];
                mem_written[addr] = 1'b1;
                mem_written[addr + 16'd1] = 1'b1;
              end
            end else begin
              unk = 1'b1;
            end
          end
          CLS_B: begin
            case (it.func3)
              BR_EQ:  cond = (c == b);
              BR_NE:  cond = (c != b);
              BR_EZ:  cond = (c == 16'd0);
              BR_NZ:  cond = (c != 16'd0);
              BR_LT:  cond = ($signed(c) < $signed(b));
              BR_GE:  cond = !($signed(c) < $signed(b));
              BR_LTU: cond = (c < b);
              default: cond = (c >= b);
            endcase
            if (cond) begin
              jmp = 1'b1;
              npc = pc_model + imm + 16'd2;
            end
          end
          CLS_L: begin
            addr = b + imm;
            if (it.func3 == MEM_B || it.func3 == MEM_BU) begin
              wr = 1'b1;
              wval = {8'h00, mem_data[addr]};
              if (it.func3 == MEM_B && mem_data[addr][7]) begin
                wval[15:8] = 8'hFF;
              end
            end else if (it.func3 == MEM_W) begin
              if (addr == 16'hFFFF) begin
                fault = 1'b1;
              end else begin
                wr = 1'b1;
                wval = {mem_data[addr + 16'd1], mem_data[addr]};
              end
            end else begin
              unk = 1'b1;
            end
          end
          CLS_J: begin
            if (it.link_flag) begin
              wr = 1'b1;
              wval = pc_model + 16'd2;
            end
            jmp = 1'b1;
            npc = pc_model + imm + 16'd2;
          end
          CLS_U: begin
            wr = 1'b1;
            wval = imm << 7;
            if (it.link_flag) begin
              wval = wval + pc_model;
            end
          end
          default: ;
        endcase
        if (wr) begin
          gpr_model[it.rd_index] = wval;
        end
        pc_model = npc;
        if ({1'b0, pc_model} >= prog_end_model) begin
          halt_model = 1'b1;
        end
      end
    end
    o.next_pc = pc_model;
    o.took_jump = jmp;
    o.reg_written = wr;
    o.dest_index = wr ? it.rd_index : 3'd0;
    o.dest_value = wr ? wval : 16'd0;
    o.unknown_op = unk;
    o.memory_fault = fault;
    o.halted_now = halt_model;
    return o;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (outcome_q.size() == 0) begin
        report("unexpected response", rsp.next_pc, 0);
      end else begin
        want_rsp = outcome_q.pop_front();
        got_rsp = {rsp.next_pc, rsp.took_jump, rsp.reg_written, rsp.dest_index,
                   rsp.dest_value, rsp.unknown_op, rsp.memory_fault, rsp.halted_now};
        if (got_rsp.next_pc !== want_rsp.next_pc)
          report("next_pc", got_rsp.next_pc, want_rsp.next_pc);
        if (got_rsp.took_jump !== want_rsp.took_jump)
          report("took_jump", got_rsp.took_jump, want_rsp.took_jump);
        if (got_rsp.reg_written !== want_rsp.reg_written)
          report("reg_written", got_rsp.reg_written, want_rsp.reg_written);
        if (got_rsp.dest_index !== want_rsp.dest_index)
          report("dest_index", got_rsp.dest_index, want_rsp.dest_index);
        if (got_rsp.dest_value !== want_rsp.dest_value)
          report("dest_value", got_rsp.dest_value, want_rsp.dest_value);
        if (got_rsp.unknown_op !== want_rsp.unknown_op)
          report("unknown_op", got_rsp.unknown_op, want_rsp.unknown_op);
        if (got_rsp.memory_fault !== want_rsp.memory_fault)
          report("memory_fault", got_rsp.memory_fault, want_rsp.memory_fault);
        if (got_rsp.halted_now !== want_rsp.halted_now)
          report("halted_now", got_rsp.halted_now, want_rsp.halted_now);
      end
    end
  end

  // one request, held until accepted; valid stays high for a back-to-back follower
  task automatic send_request(item_t it);
    while (idle_now()) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.operation <= it.operation;
    req.instr_class <= it.instr_class;
    req.func4 <= it.func4;
    req.func3 <= it.func3;
    req.rd_index <= it.rd_index;
    req.rs1_index <= it.rs1_index;
    req.rs2_index <= it.rs2_index;
    req.immediate <= it.immediate;
    req.link_flag <= it.link_flag;
    req.preload_address <= it.preload_address;
    req.preload_byte <= it.preload_byte;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic issue(item_t it);
    outcome_q = {outcome_q, execute_item(it)};
    send_request(it);
  endtask

  task automatic preload_byte(logic [15:0] addr, logic [7:0] data);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.operation = 1'b1;
    it.preload_address = addr;
    it.preload_byte = data;
    issue(it);
  endtask

  // loads only ever see bytes that were written first
  task automatic issue_guarded(item_t it);
    logic [15:0] addr;
    if (!it.operation && it.instr_class == CLS_L && !halt_model &&
        {1'b0, pc_model} < prog_end_model) begin
      addr = gpr_model[it.rs2_index] + sext_imm(it.immediate);
      if (it.func3 == MEM_B || it.func3 == MEM_BU ||
          (it.func3 == MEM_W && addr != 16'hFFFF)) begin
        if (!mem_written[addr]) preload_byte(addr, 8'($urandom));
        if (it.func3 == MEM_W && !mem_written[addr + 16'd1])
          preload_byte(addr + 16'd1, 8'($urandom));
      end
    end
    issue(it);
  endtask

  function automatic item_t make_exec(cls_e cls, logic [3:0] f4, logic [2:0] f3,
                                      logic [2:0] rd, logic [2:0] rs1, logic [2:0] rs2,
                                      logic signed [8:0] imm, logic link);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.operation = 1'b0;
    it.instr_class = cls;
    it.func4 = f4;
    it.func3 = f3;
    it.rd_index = rd;
    it.rs1_index = rs1;
    it.rs2_index = rs2;
    it.immediate = imm;
    it.link_flag = link;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [6:0] r_keys [13];
    logic [3:0] sh_kinds [3];
    r_keys = '{R_ADD, R_SUB, R_SLT, R_SLTU, R_SLL, R_SRL, R_SRA, R_OR, R_AND, R_XOR,
               R_MV, R_JR, R_JALR};
    sh_kinds = '{SH_SLL, SH_SRL, SH_SRA};
    it = item_t'({$urandom, $urandom});
    it.operation = ($urandom_range(0, 4) == 0);
    if (it.instr_class == CLS_R && $urandom_range(0, 9) != 0)
      {it.func4, it.func3} = r_keys[$urandom_range(0, 12)];
    if (it.instr_class == CLS_I && it.func3 == I_SHIFT && $urandom_range(0, 6) != 0)
      it.func4 = sh_kinds[$urandom_range(0, 2)];
    if ((it.instr_class == CLS_S || it.instr_class == CLS_L) && $urandom_range(0, 6) != 0)
      it.func3 = (it.instr_class == CLS_S) ? 3'($urandom_range(0, 1))
               : (($urandom_range(0, 2) == 0) ? MEM_BU : 3'($urandom_range(0, 1)));
    return it;
  endfunction

  task automatic write_program_end(logic [16:0] value);
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.program_end <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    prog_end_model = value;
  endtask

  task automatic test_corner_cases();
    write_program_end(PROG_END_RST);
    issue(make_exec(CLS_I, 4'd0, I_LI, 3'd1, 3'd0, 3'd0, -9'sd1, 1'b0));
    issue(make_exec(CLS_I, 4'd0, I_LI, 3'd2, 3'd0, 3'd0, 9'sd255, 1'b0));
    issue(make_exec(CLS_I, 4'd0, I_LI, 3'd3, 3'd0, 3'd0, -9'sd256, 1'b0));
    // sltui with a negative immediate compares unsigned
    issue(make_exec(CLS_I, 4'd0, I_SLTUI, 3'd2, 3'd0, 3'd0, -9'sd1, 1'b0));
    issue(make_exec(CLS_I, 4'd7, I_SHIFT, 3'd2, 3'd0, 3'd0, 9'sd3, 1'b0));
    issue(make_exec(CLS_R, 4'hF, 3'd7, 3'd2, 3'd0, 3'd1, 9'sd0, 1'b0));
    // word access at the last address faults
    issue(make_exec(CLS_S, 4'd0, MEM_W, 3'd0, 3'd1, 3'd2, 9'sd0, 1'b0));
    issue(make_exec(CLS_L, 4'd0, MEM_W, 3'd4, 3'd0, 3'd1, 9'sd0, 1'b0));
    preload_byte(16'hFFFF, 8'h80);
    issue_guarded(make_exec(CLS_L, 4'd0, MEM_B, 3'd4, 3'd0, 3'd1, 9'sd0, 1'b0));
    issue_guarded(make_exec(CLS_L, 4'd0, MEM_BU, 3'd5, 3'd0, 3'd1, 9'sd0, 1'b0));
    issue(make_exec(CLS_S, 4'd0, 3'd5, 3'd0, 3'd1, 3'd2, 9'sd0, 1'b0));
    issue(make_exec(CLS_L, 4'd0, 3'd6, 3'd4, 3'd0, 3'd1, 9'sd0, 1'b0));
    issue(make_exec(CLS_NOP, 4'd0, 3'd0, 3'd0, 3'd0, 3'd0, 9'sd0, 1'b0));
    issue(make_exec(CLS_U, 4'd0, 3'd0, 3'd6, 3'd0, 3'd0, 9'sd255, 1'b1));
    issue(make_exec(CLS_J, 4'd0, 3'd0, 3'd7, 3'd0, 3'd0, 9'sd20, 1'b1));
    // jalr with rd equal to rs2 jumps to the old register value
    issue(make_exec(CLS_R, R_JALR[6:3], R_JALR[2:0], 3'd2, 3'd0, 3'd2, 9'sd0, 1'b0));
    issue(make_exec(CLS_B, 4'd0, BR_LT, 3'd0, 3'd1, 3'd0, -9'sd4, 1'b0));
  endtask

  task automatic test_random_stream(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      no_idle = (n >= count / 3) && (n < count / 2);
      issue_guarded(random_item());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_program_end();
    write_program_end({1'b0, pc_model} + 17'd40);
    test_random_stream(40);
    write_program_end(17'd0);
    test_random_stream(30);
    write_program_end(PROG_END_RST);
    test_random_stream(20);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.operation = 1'b0;
    req.instr_class = '0;
    req.func4 = '0;
    req.func3 = '0;
    req.rd_index = '0;
    req.rs1_index = '0;
    req.rs2_index = '0;
    req.immediate = '0;
    req.link_flag = 1'b0;
    req.preload_address = '0;
    req.preload_byte = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.program_end = PROG_END_RST;
    for (int i = 0; i < NUM_REGS; i++) gpr_model[i] = '0;
    pc_model = '0;
    halt_model = 1'b0;
    prog_end_model = PROG_END_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_random_stream(1850);
    test_program_end();

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("** risc16_execute_unit: PASSED **");
    end else begin
      $display("** risc16_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule
